// File: design/phhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pulsed heater hysteresis controller.
package phhc_pkg;

  localparam int TIMER_BITS = 24;
  localparam int TIME_W     = 24;
  localparam int TEMP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [TIME_W-1:0] BURST_RESET     = TIME_W'(1 * 1000);
  localparam logic [TIME_W-1:0] REST_RESET      = TIME_W'(10 * 1000);
  localparam logic [TEMP_W-1:0] UPPER_RESET     = TEMP_W'(0);
  localparam logic [TEMP_W-1:0] LOWER_RESET     = TEMP_W'(5);
  localparam logic [TEMP_W-1:0] MAX_TGT_RESET   = TEMP_W'(200);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BURST = 2'd1,
    PH_REST  = 2'd2,
    PH_OVER  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SAMPLE  = 2'd1,
    MODE_ENABLE  = 2'd2,
    MODE_DISABLE = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BURST_TIME = 3'd0,
    REG_REST_TIME  = 3'd1,
    REG_UPPER      = 3'd2,
    REG_LOWER      = 3'd3,
    REG_MAX_TARGET = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] burst_time_ms;
    logic [TIME_W-1:0] rest_time_ms;
    logic [TEMP_W-1:0] upper_margin;
    logic [TEMP_W-1:0] lower_margin;
    logic [TEMP_W-1:0] max_target;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [TEMP_W-1:0] temperature;
    logic [TEMP_W-1:0] target;
  } item_t;

endpackage

// File: design/phhc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the heater controller.
module phhc_cfg_regs
  import phhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_time_ms <= BURST_RESET;
      cfg.rest_time_ms  <= REST_RESET;
      cfg.upper_margin  <= UPPER_RESET;
      cfg.lower_margin  <= LOWER_RESET;
      cfg.max_target    <= MAX_TGT_RESET;
    end else if (we) begin
      case (index)
        REG_BURST_TIME: cfg.burst_time_ms <= data[TIME_W-1:0];
        REG_REST_TIME:  cfg.rest_time_ms  <= data[TIME_W-1:0];
        REG_UPPER:      cfg.upper_margin  <= data[TEMP_W-1:0];
        REG_LOWER:      cfg.lower_margin  <= data[TEMP_W-1:0];
        REG_MAX_TARGET: cfg.max_target    <= data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/phhc_in_stage.sv
`timescale 1ns / 1ps
// Input register stage: captures one item and holds it until the core takes it.
module phhc_in_stage
  import phhc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  held_valid,
  output item_t held_item,
  input  logic  take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// File: design/phhc_ctrl.sv
`timescale 1ns / 1ps
// Phase state, one-step evaluation and the result register.
module phhc_ctrl
  import phhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              item_valid,
  input  item_t             item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              heater_pin,
  output phase_t            phase,
  output logic [TIME_W-1:0] ms_left
);

  phase_t                phase_reg, phase_next, phase_mid;
  logic [TIMER_BITS-1:0] countdown, countdown_next, countdown_mid;
  logic [TEMP_W-1:0]     target_reg, target_next;
  logic [TEMP_W-1:0]     last_temperature, last_temperature_next;
  logic                  drive, drive_next, drive_mid;
  logic [TIMER_BITS-1:0] burst_load, rest_load;
  logic [TEMP_W:0]       hot_limit, cool_sum;
  logic                  hot, cool;

  assign burst_load = TIMER_BITS'(cfg.burst_time_ms);
  assign rest_load  = TIMER_BITS'(cfg.rest_time_ms);
  assign take       = !out_valid || out_ready;

  // Apply the item itself.
  always_comb begin
    phase_mid             = phase_reg;
    countdown_mid         = countdown;
    target_next           = target_reg;
    last_temperature_next = last_temperature;
    drive_mid             = drive;
    case (item.mode)
      MODE_TICK: begin
        if (countdown != '0) countdown_mid = countdown - 1'b1;
      end
      MODE_SAMPLE: begin
        last_temperature_next = item.temperature;
      end
      MODE_ENABLE: begin
        if (item.target == '0) begin
          phase_mid     = PH_IDLE;
          countdown_mid = '0;
          drive_mid     = 1'b0;
        end else begin
          target_next   = (item.target > cfg.max_target) ? cfg.max_target : item.target;
          phase_mid     = PH_BURST;
          countdown_mid = burst_load;
          drive_mid     = 1'b1;
        end
      end
      default: begin
        phase_mid     = PH_IDLE;
        countdown_mid = '0;
        drive_mid     = 1'b0;
      end
    endcase
  end

  assign hot_limit = {1'b0, target_next} + {1'b0, cfg.upper_margin};
  assign cool_sum  = {1'b0, last_temperature_next} + {1'b0, cfg.lower_margin};
  assign hot       = {1'b0, last_temperature_next} > hot_limit;
  assign cool      = cool_sum < {1'b0, target_next};

  // One phase evaluation; overtemperature wins over timer expiry.
  always_comb begin
    phase_next     = phase_mid;
    countdown_next = countdown_mid;
    drive_next     = drive_mid;
    case (phase_mid)
      PH_BURST: begin
        if (hot) begin
          phase_next     = PH_OVER;
          countdown_next = '0;
          drive_next     = 1'b0;
        end else if (countdown_mid == '0) begin
          phase_next     = PH_REST;
          countdown_next = rest_load;
          drive_next     = 1'b0;
        end
      end
      PH_REST: begin
        if (hot) begin
          phase_next     = PH_OVER;
          countdown_next = '0;
          drive_next     = 1'b0;
        end else if (countdown_mid == '0) begin
          phase_next     = PH_BURST;
          countdown_next = burst_load;
          drive_next     = 1'b1;
        end
      end
      PH_OVER: begin
        if (cool) begin
          phase_next     = PH_BURST;
          countdown_next = burst_load;
          drive_next     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg        <= PH_IDLE;
      countdown        <= '0;
      target_reg       <= '0;
      last_temperature <= MAX_TGT_RESET;
      drive            <= 1'b0;
      out_valid        <= 1'b0;
    end else if (take) begin
      out_valid <= item_valid;
      if (item_valid) begin
        phase_reg        <= phase_next;
        countdown        <= countdown_next;
        target_reg       <= target_next;
        last_temperature <= last_temperature_next;
        drive            <= drive_next;
      end
    end
  end

  // Result register: payload only, loaded with the step's outcome.
  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      heater_pin <= drive_next;
      phase      <= phase_next;
      ms_left    <= TIME_W'(countdown_next);
    end
  end

endmodule

// File: design/pulsed_heater_hysteresis_controller.sv
`timescale 1ns / 1ps
// Top level of the pulsed heater hysteresis controller.
//
//   channel  handshake                 payload
//   in       in_valid / in_ready       mode, temperature, target
//   out      out_valid / out_ready     heater_pin, phase, ms_left
//   cfg      cfg_we (no wait)          cfg_index, cfg_data
//
// One item per cycle sustained while out_ready holds; an item passes the input register, then the result register.
// The phase logic and the millisecond counter update are combinational between the input
// register and the result register, so every item sees the state left by the previous one.
// Synchronous reset returns idle phase, cleared counter and target, and the reset config.
// A stalled result holds; while it waits, the input register still takes one item if empty.
module pulsed_heater_hysteresis_controller
  import phhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [TEMP_W-1:0]     temperature,
  input  logic [TEMP_W-1:0]     target,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  heater_pin,
  output logic [1:0]            phase,
  output logic [TIME_W-1:0]     ms_left,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  item_t  in_item, held_item;
  logic   held_valid, take;
  phase_t phase_out;

  assign in_item.mode        = mode_t'(mode);
  assign in_item.temperature = temperature;
  assign in_item.target      = target;
  assign phase               = phase_out;

  phhc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  phhc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  phhc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (held_valid),
    .item       (held_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .heater_pin (heater_pin),
    .phase      (phase_out),
    .ms_left    (ms_left)
  );

  a_drive_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heater_pin == (phase_out == PH_BURST)))
    else $error("heater drive disagrees with phase");

  a_count_clear_when_stopped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase_out == PH_IDLE || phase_out == PH_OVER)) |-> (ms_left == '0))
    else $error("counter not cleared in idle or overtemperature");

  a_held_item_moves: assert property (@(posedge clk) disable iff (rst)
    (held_valid && take) |=> out_valid)
    else $error("taken item produced no result");

endmodule
